@@ design/bes_pkg.sv @@
// bes_pkg: shared types and constants of the bumper escape sequencer
// phase, direction and command codes, escape distances and angles
// no dependencies
`default_nettype none

package bes_pkg;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_FRONT      = 3'd1,
    PH_FRONT_WAIT = 3'd2,
    PH_LEFT       = 3'd3,
    PH_LEFT_WAIT  = 3'd4,
    PH_RIGHT      = 3'd5,
    PH_RIGHT_WAIT = 3'd6,
    PH_WAIT_END   = 3'd7
  } phase_t;

  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BWD   = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [1:0] ISSUE_NONE   = 2'd0;
  localparam logic [1:0] ISSUE_MOVE   = 2'd1;
  localparam logic [1:0] ISSUE_ROTATE = 2'd2;
  localparam logic [1:0] ISSUE_DRIVE  = 2'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BUMP = 1'b1;

  localparam logic [1:0] REG_BACKOFF_SPEED = 2'd0;
  localparam logic [1:0] REG_TURN_SPEED    = 2'd1;
  localparam logic [1:0] REG_BUMP_LIMIT    = 2'd2;

  localparam logic [7:0] BACKOFF_SPEED_RST = 8'd80;
  localparam logic [7:0] TURN_SPEED_RST    = 8'd60;
  localparam logic [7:0] BUMP_LIMIT_RST    = 8'd3;

  // distances in mm, angles in degrees
  localparam logic [7:0] FRONT_BACK_LONG  = 8'd200;
  localparam logic [7:0] FRONT_BACK_SHORT = 8'd140;
  localparam logic [7:0] FRONT_TURN_LONG  = 8'd110;
  localparam logic [7:0] FRONT_TURN_SHORT = 8'd75;
  localparam logic [7:0] SIDE_BACK_LONG   = 8'd160;
  localparam logic [7:0] SIDE_BACK_SHORT  = 8'd100;
  localparam logic [7:0] SIDE_TURN_LONG   = 8'd100;
  localparam logic [7:0] SIDE_TURN_SHORT  = 8'd65;

  typedef struct packed {
    logic [1:0] issue;
    logic [7:0] speed;
    logic [1:0] direction;
    logic [7:0] amount;
    logic       active;
    logic [2:0] phase;
  } result_t;

endpackage

`default_nettype wire

@@ design/bumper_escape_sequencer_unit.sv @@
// bumper_escape_sequencer_unit: collision escape phase machine with motor command issue
// result is registered; one item per cycle while out_ready is high
// result register plus skid register keep in_ready up while one result waits
// reset: synchronous rst returns phase to idle, clears the hit count, pending flags and
// command, and loads the speed and limit registers with their defaults
// depends on bes_pkg
`default_nettype none

module bumper_escape_sequencer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       operation,
  input  wire logic       bump_left,
  input  wire logic       bump_right,
  input  wire logic       motion_done,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      issue,
  output logic [7:0]      speed,
  output logic [1:0]      direction,
  output logic [7:0]      amount,
  output logic            active,
  output logic [2:0]      phase,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] backoff_speed;
  logic [7:0] turn_speed;
  logic [7:0] bump_limit;

  bes_pkg::phase_t seq_phase, seq_phase_next;
  logic [7:0] hit_count, hit_count_next;
  logic       move_pending, move_pending_next;
  logic       rotate_pending, rotate_pending_next;
  logic [7:0] pending_amount, pending_amount_next;
  logic [7:0] cmd_speed, cmd_speed_next;
  logic [1:0] cmd_direction, cmd_direction_next;

  bes_pkg::result_t res_next;
  bes_pkg::result_t out_res;
  bes_pkg::result_t skid_res;
  logic             skid_valid;
  logic             in_xfer;

  assign in_ready = !skid_valid;
  assign in_xfer  = in_valid && in_ready;

  // one pass: phase step, then command issue from the stepped state
  always_comb begin
    logic       over;
    logic [8:0] sum;
    logic [7:0] inc;
    seq_phase_next      = seq_phase;
    hit_count_next      = hit_count;
    move_pending_next   = move_pending;
    rotate_pending_next = rotate_pending;
    pending_amount_next = pending_amount;
    cmd_speed_next      = cmd_speed;
    cmd_direction_next  = cmd_direction;
    res_next            = '0;
    over                = hit_count > bump_limit;
    inc                 = 8'd1;
    sum                 = 9'd0;

    if (operation == bes_pkg::OP_BUMP) begin
      if (bump_left && bump_right) begin
        seq_phase_next = bes_pkg::PH_FRONT;
      end else if (bump_left) begin
        if (seq_phase != bes_pkg::PH_FRONT_WAIT) seq_phase_next = bes_pkg::PH_LEFT;
      end else if (bump_right) begin
        if (seq_phase != bes_pkg::PH_FRONT_WAIT) seq_phase_next = bes_pkg::PH_RIGHT;
      end
    end else begin
      unique case (seq_phase)
        bes_pkg::PH_FRONT, bes_pkg::PH_LEFT, bes_pkg::PH_RIGHT: begin
          cmd_speed_next     = backoff_speed;
          cmd_direction_next = bes_pkg::DIR_BWD;
          move_pending_next  = 1'b1;
          if (seq_phase == bes_pkg::PH_FRONT) begin
            inc                 = 8'd2;
            pending_amount_next = over ? bes_pkg::FRONT_BACK_LONG
                                       : bes_pkg::FRONT_BACK_SHORT;
            seq_phase_next      = bes_pkg::PH_FRONT_WAIT;
          end else begin
            pending_amount_next = over ? bes_pkg::SIDE_BACK_LONG
                                       : bes_pkg::SIDE_BACK_SHORT;
            seq_phase_next      = (seq_phase == bes_pkg::PH_LEFT) ?
                                  bes_pkg::PH_LEFT_WAIT : bes_pkg::PH_RIGHT_WAIT;
          end
          // saturating count
          sum            = {1'b0, hit_count} + {1'b0, inc};
          hit_count_next = sum[8] ? 8'hff : sum[7:0];
        end
        bes_pkg::PH_FRONT_WAIT: begin
          if (!move_pending) begin
            cmd_speed_next = turn_speed;
            if (over) begin
              pending_amount_next = bes_pkg::FRONT_TURN_LONG;
              cmd_direction_next  = bes_pkg::DIR_RIGHT;
              hit_count_next      = '0;
            end else begin
              pending_amount_next = bes_pkg::FRONT_TURN_SHORT;
              cmd_direction_next  = bes_pkg::DIR_LEFT;
            end
            rotate_pending_next = 1'b1;
            seq_phase_next      = bes_pkg::PH_WAIT_END;
          end
        end
        bes_pkg::PH_LEFT_WAIT, bes_pkg::PH_RIGHT_WAIT: begin
          if (!move_pending) begin
            cmd_speed_next     = turn_speed;
            cmd_direction_next = (seq_phase == bes_pkg::PH_LEFT_WAIT) ?
                                 bes_pkg::DIR_RIGHT : bes_pkg::DIR_LEFT;
            if (over) begin
              pending_amount_next = bes_pkg::SIDE_TURN_LONG;
              hit_count_next      = '0;
            end else begin
              pending_amount_next = bes_pkg::SIDE_TURN_SHORT;
            end
            rotate_pending_next = 1'b1;
            seq_phase_next      = bes_pkg::PH_WAIT_END;
          end
        end
        bes_pkg::PH_WAIT_END: begin
          if (!(move_pending || rotate_pending)) seq_phase_next = bes_pkg::PH_IDLE;
        end
        default: begin
        end
      endcase

      if (seq_phase_next != bes_pkg::PH_IDLE) begin
        if (pending_amount_next != 8'd0) begin
          if (rotate_pending_next || move_pending_next) begin
            res_next.issue     = rotate_pending_next ? bes_pkg::ISSUE_ROTATE
                                                     : bes_pkg::ISSUE_MOVE;
            res_next.speed     = cmd_speed_next;
            res_next.direction = cmd_direction_next;
            res_next.amount    = pending_amount_next;
          end
          pending_amount_next = '0;
        end else if (!(move_pending_next || rotate_pending_next)) begin
          res_next.issue     = bes_pkg::ISSUE_DRIVE;
          res_next.speed     = cmd_speed_next;
          res_next.direction = cmd_direction_next;
        end else if (motion_done) begin
          move_pending_next   = 1'b0;
          rotate_pending_next = 1'b0;
        end
      end
    end

    res_next.active = seq_phase_next != bes_pkg::PH_IDLE;
    res_next.phase  = seq_phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_speed <= bes_pkg::BACKOFF_SPEED_RST;
      turn_speed    <= bes_pkg::TURN_SPEED_RST;
      bump_limit    <= bes_pkg::BUMP_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bes_pkg::REG_BACKOFF_SPEED: backoff_speed <= cfg_data;
        bes_pkg::REG_TURN_SPEED:    turn_speed    <= cfg_data;
        bes_pkg::REG_BUMP_LIMIT:    bump_limit    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase      <= bes_pkg::PH_IDLE;
      hit_count      <= '0;
      move_pending   <= 1'b0;
      rotate_pending <= 1'b0;
      pending_amount <= '0;
      cmd_speed      <= '0;
      cmd_direction  <= bes_pkg::DIR_FWD;
    end else if (in_xfer) begin
      seq_phase      <= seq_phase_next;
      hit_count      <= hit_count_next;
      move_pending   <= move_pending_next;
      rotate_pending <= rotate_pending_next;
      pending_amount <= pending_amount_next;
      cmd_speed      <= cmd_speed_next;
      cmd_direction  <= cmd_direction_next;
    end
  end

  // result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_xfer) begin
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      skid_res   <= res_next;
      skid_valid <= 1'b1;
    end
  end

  assign issue     = out_res.issue;
  assign speed     = out_res.speed;
  assign direction = out_res.direction;
  assign amount    = out_res.amount;
  assign active    = out_res.active;
  assign phase     = out_res.phase;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench for bumper_escape_sequencer_unit
// predicts every motor command and phase from its own escape model, random idling on both sides
// depends on bes_pkg and bumper_escape_sequencer_unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bes_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_TICK;
  logic bump_left = 1'b0;
  logic bump_right = 1'b0;
  logic motion_done = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] issue;
  logic [7:0] speed;
  logic [1:0] direction;
  logic [7:0] amount;
  logic active;
  logic [2:0] phase;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_BACKOFF_SPEED;
  logic [7:0] cfg_data = 8'd0;

  // escape model state, mirrors the block after every accepted item
  logic [7:0] cfg_backoff = BACKOFF_SPEED_RST;
  logic [7:0] cfg_turn = TURN_SPEED_RST;
  logic [7:0] cfg_limit = BUMP_LIMIT_RST;
  phase_t esc_phase = PH_IDLE;
  logic [7:0] hit_count = 8'd0;
  logic move_pend = 1'b0;
  logic rot_pend = 1'b0;
  logic [7:0] pend_amt = 8'd0;
  logic [7:0] cmd_spd = 8'd0;
  logic [1:0] cmd_dir = DIR_FWD;

  result_t expected_cmds[$];

  int items_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int config_loads = 0;
  int long_escapes = 0;
  int ceiling_items = 0;
  int idle_cycles = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int stall_left = 0;

  bumper_escape_sequencer_unit dut (.*);

  always #5ns clk = ~clk;

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic void add_bumps(int n);
    int sum;
    sum = int'(hit_count) + n;
    hit_count = (sum > 255) ? 8'hff : sum[7:0];
  endfunction

  function automatic void start_backoff(logic [7:0] far_mm, logic [7:0] near_mm, phase_t nxt,
                                        int inc);
    cmd_spd = cfg_backoff;
    cmd_dir = DIR_BWD;
    move_pend = 1'b1;
    pend_amt = (hit_count > cfg_limit) ? far_mm : near_mm;
    esc_phase = nxt;
    add_bumps(inc);
  endfunction

  // the front escape picks its turn side by the count, side escapes always turn away
  function automatic void start_turn(logic [1:0] far_dir, logic [1:0] near_dir,
                                     logic [7:0] far_deg, logic [7:0] near_deg);
    cmd_spd = cfg_turn;
    if (hit_count > cfg_limit) begin
      cmd_dir = far_dir;
      pend_amt = far_deg;
      hit_count = 8'd0;
      long_escapes++;
    end else begin
      cmd_dir = near_dir;
      pend_amt = near_deg;
    end
    rot_pend = 1'b1;
    esc_phase = PH_WAIT_END;
  endfunction

  function automatic result_t escape_step(logic op, logic lft, logic rgt, logic done);
    result_t r;
    r = '0;
    if (op == OP_BUMP) begin
      if (lft && rgt) begin
        esc_phase = PH_FRONT;
      end else if ((lft || rgt) && esc_phase != PH_FRONT_WAIT) begin
        esc_phase = lft ? PH_LEFT : PH_RIGHT;
      end
    end else begin
      case (esc_phase)
        PH_FRONT: start_backoff(FRONT_BACK_LONG, FRONT_BACK_SHORT, PH_FRONT_WAIT, 2);
        PH_FRONT_WAIT: if (!move_pend) begin
          start_turn(DIR_RIGHT, DIR_LEFT, FRONT_TURN_LONG, FRONT_TURN_SHORT);
        end
        PH_LEFT: start_backoff(SIDE_BACK_LONG, SIDE_BACK_SHORT, PH_LEFT_WAIT, 1);
        PH_LEFT_WAIT: if (!move_pend) begin
          start_turn(DIR_RIGHT, DIR_RIGHT, SIDE_TURN_LONG, SIDE_TURN_SHORT);
        end
        PH_RIGHT: start_backoff(SIDE_BACK_LONG, SIDE_BACK_SHORT, PH_RIGHT_WAIT, 1);
        PH_RIGHT_WAIT: if (!move_pend) begin
          start_turn(DIR_LEFT, DIR_LEFT, SIDE_TURN_LONG, SIDE_TURN_SHORT);
        end
        PH_WAIT_END: if (!(move_pend || rot_pend)) begin
          esc_phase = PH_IDLE;
        end
        default: ;
      endcase
      if (esc_phase != PH_IDLE) begin
        if (pend_amt != 8'd0) begin
          // a rotate wins over a move when both are outstanding
          if (rot_pend || move_pend) begin
            r.issue = rot_pend ? ISSUE_ROTATE : ISSUE_MOVE;
            r.speed = cmd_spd;
            r.direction = cmd_dir;
            r.amount = pend_amt;
          end
          pend_amt = 8'd0;
        end else if (!(move_pend || rot_pend)) begin
          r.issue = ISSUE_DRIVE;
          r.speed = cmd_spd;
          r.direction = cmd_dir;
        end else if (done) begin
          move_pend = 1'b0;
          rot_pend = 1'b0;
        end
      end
    end
    r.active = (esc_phase != PH_IDLE);
    r.phase = esc_phase;
    return r;
  endfunction

  task automatic send_item(input logic op, input logic lft, input logic rgt, input logic done);
    int gap;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    bump_left <= lft;
    bump_right <= rgt;
    motion_done <= done;
    do @(posedge clk); while (!in_ready);
    expected_cmds.push_back(escape_step(op, lft, rgt, done));
    items_sent++;
    if (hit_count == 8'hff) ceiling_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] bs, input logic [7:0] ts, input logic [7:0] lim);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_BACKOFF_SPEED;
    cfg_data <= bs;
    @(posedge clk);
    cfg_backoff = bs;
    cfg_index <= REG_TURN_SPEED;
    cfg_data <= ts;
    @(posedge clk);
    cfg_turn = ts;
    cfg_index <= REG_BUMP_LIMIT;
    cfg_data <= lim;
    @(posedge clk);
    cfg_limit = lim;
    cfg_write <= 1'b0;
    config_loads++;
  endtask

  // one escape: a bumper event, then ticks until the sequence goes idle or max_ticks run out, with some noise
  task automatic run_escape(input int max_ticks, input int done_pct);
    logic lft;
    logic rgt;
    int n;
    case ($urandom_range(2))
      0: begin lft = 1'b1; rgt = 1'b1; end
      1: begin lft = 1'b1; rgt = 1'b0; end
      default: begin lft = 1'b0; rgt = 1'b1; end
    endcase
    send_item(OP_BUMP, lft, rgt, 1'($urandom_range(1)));
    for (n = 0; n < max_ticks && esc_phase != PH_IDLE; n++) begin
      if ($urandom_range(9) == 0) begin
        send_item(OP_BUMP, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        send_item(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(99) < done_pct);
      end
    end
  endtask

  task automatic run_escapes(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      in_gap_pct = ($urandom_range(3) == 0) ? 0 : 30;
      out_stall_pct = ($urandom_range(3) == 0) ? 0 : 30;
      run_escape(40, $urandom_range(70, 20));
    end
  endtask

  task automatic test_directed();
    in_gap_pct = 0;
    out_stall_pct = 0;
    send_item(OP_TICK, 1'b1, 1'b1, 1'b1);   // tick while idle
    send_item(OP_BUMP, 1'b0, 1'b0, 1'b1);   // no bumper pressed
    send_item(OP_BUMP, 1'b1, 1'b0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0);   // short side back-off
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0);
    send_item(OP_BUMP, 1'b0, 1'b1, 1'b1);   // side hit during side wait restarts
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0, 1'b1);
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0);   // turn away from the right hit
    send_item(OP_TICK, 1'b0, 1'b0, 1'b1);
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0);   // back to idle
    send_item(OP_BUMP, 1'b1, 1'b1, 1'b0);
    send_item(OP_TICK, 1'b1, 1'b0, 1'b1);   // front back-off, count now above limit
    send_item(OP_BUMP, 1'b1, 1'b0, 1'b1);   // side hits ignored in front wait
    send_item(OP_BUMP, 1'b0, 1'b1, 1'b0);
    send_item(OP_BUMP, 1'b0, 1'b0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b1, 1'b1);
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0);   // long right turn clears the count
    send_item(OP_BUMP, 1'b1, 1'b1, 1'b0);   // front hit while rotation outstanding
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b0, 1'b1);
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0);   // short left turn
    send_item(OP_TICK, 1'b0, 1'b0, 1'b1);
    send_item(OP_TICK, 1'b0, 1'b0, 1'b0);
    send_item(OP_TICK, 1'b1, 1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic test_escape_mix();
    set_config(BACKOFF_SPEED_RST, TURN_SPEED_RST, BUMP_LIMIT_RST);
    run_escapes(200);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    set_config(8'd0, 8'd0, 8'd0);
    run_escapes(80);
    set_config(8'hff, 8'hff, 8'hff);
    run_escapes(80);
    set_config(8'hff, 8'd0, 8'd1);
    run_escapes(80);
    set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(6)));
    run_escapes(80);
    wait_idle();
  endtask

  // limit at the ceiling keeps the count from clearing so it has to saturate
  task automatic test_count_saturation();
    int extra;
    extra = 0;
    set_config(cfg_backoff, cfg_turn, 8'hff);
    in_gap_pct = 15;
    out_stall_pct = 15;
    while (extra < 10) begin
      if ($urandom_range(3) != 0) begin
        send_item(OP_BUMP, 1'b1, 1'b1, 1'($urandom_range(1)));
      end else begin
        send_item(OP_BUMP, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
      send_item(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
      if (hit_count == 8'hff) extra++;
    end
    set_config(cfg_backoff, cfg_turn, 8'hfe);
    run_escapes(40);
    wait_idle();
  endtask

  task automatic test_backpressure();
    in_gap_pct = 0;
    out_stall_pct = 0;
    hold_req++;
    repeat (60) begin
      send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end
    // sender stops until the queue is empty, then the receiver holds again
    wait_idle();
    hold_req++;
    run_escapes(40);
    wait_idle();
  endtask

  task automatic test_random_items();
    in_gap_pct = 30;
    out_stall_pct = 30;
    repeat (80) begin
      send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      stall_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap(out_stall_pct);
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {issue, speed, direction, amount, active, phase};
      results_checked++;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result issue %0d speed %0d dir %0d amount %0d active %0d phase %0d",
                   $realtime, got.issue, got.speed, got.direction, got.amount, got.active,
                   got.phase);
        end
      end else begin
        want = expected_cmds.pop_front();
        if (got.issue !== want.issue || got.speed !== want.speed ||
            got.direction !== want.direction || got.amount !== want.amount ||
            got.active !== want.active || got.phase !== want.phase) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: expected issue %0d speed %0d dir %0d amount %0d active %0d phase %0d",
                     $realtime, want.issue, want.speed, want.direction, want.amount,
                     want.active, want.phase);
            $display("%0t: got      issue %0d speed %0d dir %0d amount %0d active %0d phase %0d",
                     $realtime, got.issue, got.speed, got.direction, got.amount, got.active,
                     got.phase);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer in %0d cycles, %0d results outstanding",
                 idle_cycles, expected_cmds.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_escape_mix();
    test_config_extremes();
    test_count_saturation();
    test_backpressure();
    test_random_items();
    wait_idle();
    $display("covered %0d items and %0d results over %0d register settings",
             items_sent, results_checked, config_loads);
    $display("%0d long escapes, %0d items with the bump count at its ceiling, %0d mismatches",
             long_escapes, ceiling_items, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/bes_pkg.sv
design/bumper_escape_sequencer_unit.sv
sim/tb_top.sv
